@@ rtl/core/ntvs_pkg.sv @@
// ----------------------------------------------------------------------------
// ntvs_pkg: shared types and constants for the nearest table value snap core
// Field widths, function and range codes, the search token control group and
// the fetch sequencer states.
// ----------------------------------------------------------------------------
package ntvs_pkg;

  // default sizing of the note table
  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_VALUE_BITS  = 24;

  // fixed field widths on the ports
  localparam int unsigned FIELD_VALUE_W = 24;
  localparam int unsigned FIELD_INDEX_W = 8;
  localparam int unsigned COUNT_W       = 9;

  // function codes carried in tuser of the input word
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // range flag of a result
  typedef enum logic [1:0] {
    RANGE_INSIDE = 2'd0,
    RANGE_BELOW  = 2'd1,
    RANGE_ABOVE  = 2'd2,
    RANGE_EMPTY  = 2'd3
  } range_flag_t;

  // head fetch sequencer
  typedef enum logic [1:0] {
    HEAD_IDLE,
    HEAD_FIRST,
    HEAD_LAST
  } head_state_t;

  // control part of the token passed along the cell chain
  typedef struct packed {
    logic        valid;
    range_flag_t flag;
  } snap_ctl_t;

endpackage

@@ rtl/core/ntvs_ram.sv @@
// ----------------------------------------------------------------------------
// ntvs_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ntvs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ntvs_head.sv @@
// ----------------------------------------------------------------------------
// ntvs_head: query entry and end-point fetch
// Reads the first and the last valid entry of its table copy, decides the
// range flag and launches the search token into the cell chain.
// ----------------------------------------------------------------------------
module ntvs_head
  import ntvs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS,
  localparam int unsigned IDXW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  // query launch
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] query,
  input  logic [COUNT_W-1:0]    entry_count,
  // table write
  input  logic                  wr_en,
  input  logic [IDXW-1:0]       wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  // token to first cell
  output snap_ctl_t             out_ctl,
  output logic [IDXW-1:0]       out_lo,
  output logic [IDXW-1:0]       out_hi,
  output logic [VALUE_BITS-1:0] out_lo_val,
  output logic [VALUE_BITS-1:0] out_hi_val,
  output logic [VALUE_BITS-1:0] out_v
);

  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CNTW > COUNT_W) ? CNTW : COUNT_W;

  head_state_t           state;
  head_state_t           state_next;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] lo_val;
  logic [IDXW-1:0]       last;
  logic                  empty;

  logic [IDXW-1:0]       rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic [CMPW-1:0]       cnt_ext;
  logic [CMPW-1:0]       n_sat;

  // count saturated to the table depth
  assign cnt_ext = CMPW'(entry_count);
  assign n_sat   = (cnt_ext > CMPW'(TABLE_DEPTH)) ? CMPW'(TABLE_DEPTH) : cnt_ext;

  ntvs_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HEAD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query payload and first entry
  always_ff @(posedge clk) begin
    if (state == HEAD_IDLE && start) begin
      v     <= query;
      last  <= IDXW'(n_sat - CMPW'(1));
      empty <= (n_sat == '0);
    end
    if (state == HEAD_FIRST) begin
      lo_val <= rd_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      HEAD_IDLE:  if (start) state_next = HEAD_FIRST;
      HEAD_FIRST: state_next = HEAD_LAST;
      HEAD_LAST:  state_next = HEAD_IDLE;
      default:    state_next = HEAD_IDLE;
    endcase
  end

  // read address and token outputs
  always_comb begin
    rd_addr       = '0;
    out_ctl.valid = 1'b0;
    out_ctl.flag  = RANGE_INSIDE;
    unique case (state)
      HEAD_IDLE:  rd_addr = '0;
      HEAD_FIRST: rd_addr = last;
      HEAD_LAST: begin
        out_ctl.valid = 1'b1;
        priority if (empty) begin
          out_ctl.flag = RANGE_EMPTY;
        end else if (v <= lo_val) begin
          out_ctl.flag = RANGE_BELOW;
        end else if (v > rd_data) begin
          out_ctl.flag = RANGE_ABOVE;
        end else begin
          out_ctl.flag = RANGE_INSIDE;
        end
      end
      default: rd_addr = '0;
    endcase
  end

  assign out_lo     = '0;
  assign out_hi     = last;
  assign out_lo_val = lo_val;
  assign out_hi_val = rd_data;
  assign out_v      = v;

endmodule

@@ rtl/core/ntvs_cell.sv @@
// ----------------------------------------------------------------------------
// ntvs_cell: one bisection step of the search chain
// Holds its own copy of the note table. The midpoint of the incoming token
// addresses the copy; the next cycle the cell narrows lo or hi and hands the
// token on.
// ----------------------------------------------------------------------------
module ntvs_cell
  import ntvs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS,
  localparam int unsigned IDXW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  // table write
  input  logic                  wr_en,
  input  logic [IDXW-1:0]       wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  // token from the previous cell
  input  snap_ctl_t             in_ctl,
  input  logic [IDXW-1:0]       in_lo,
  input  logic [IDXW-1:0]       in_hi,
  input  logic [VALUE_BITS-1:0] in_lo_val,
  input  logic [VALUE_BITS-1:0] in_hi_val,
  input  logic [VALUE_BITS-1:0] in_v,
  // token to the next cell
  output snap_ctl_t             out_ctl,
  output logic [IDXW-1:0]       out_lo,
  output logic [IDXW-1:0]       out_hi,
  output logic [VALUE_BITS-1:0] out_lo_val,
  output logic [VALUE_BITS-1:0] out_hi_val,
  output logic [VALUE_BITS-1:0] out_v
);

  snap_ctl_t             ctl;
  logic [IDXW-1:0]       lo;
  logic [IDXW-1:0]       hi;
  logic [VALUE_BITS-1:0] lo_val;
  logic [VALUE_BITS-1:0] hi_val;
  logic [VALUE_BITS-1:0] v;

  logic [IDXW:0]         in_sum;
  logic [IDXW:0]         sum;
  logic [IDXW-1:0]       mid;
  logic [VALUE_BITS-1:0] mid_val;
  logic                  active;

  // midpoint of the arriving token addresses the table copy
  assign in_sum = {1'b0, in_lo} + {1'b0, in_hi};

  ntvs_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(in_sum[IDXW:1]),
    .rdata(mid_val)
  );

  // token registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= in_ctl.valid;
    end
    ctl.flag <= in_ctl.flag;
    lo       <= in_lo;
    hi       <= in_hi;
    lo_val   <= in_lo_val;
    hi_val   <= in_hi_val;
    v        <= in_v;
  end

  // bisection step, only for an inside token whose search window spans more than one gap
  assign sum    = {1'b0, lo} + {1'b0, hi};
  assign mid    = sum[IDXW:1];
  assign active = (ctl.flag == RANGE_INSIDE) && (IDXW'(hi - lo) > IDXW'(1));

  always_comb begin
    out_lo     = lo;
    out_hi     = hi;
    out_lo_val = lo_val;
    out_hi_val = hi_val;
    if (active) begin
      if (mid_val >= v) begin
        out_hi     = mid;
        out_hi_val = mid_val;
      end else begin
        out_lo     = mid;
        out_lo_val = mid_val;
      end
    end
  end

  assign out_ctl = ctl;
  assign out_v   = v;

endmodule

@@ rtl/core/ntvs_tail.sv @@
// ----------------------------------------------------------------------------
// ntvs_tail: neighbor choice and result register
// Picks the nearer of the two final neighbors (ties to the lower index), the
// clamp entry or, if empty, the query at index 0; holds the result for output.
// ----------------------------------------------------------------------------
module ntvs_tail
  import ntvs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS,
  localparam int unsigned IDXW = $clog2(TABLE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  // token from the last cell
  input  snap_ctl_t                in_ctl,
  input  logic [IDXW-1:0]          in_lo,
  input  logic [IDXW-1:0]          in_hi,
  input  logic [VALUE_BITS-1:0]    in_lo_val,
  input  logic [VALUE_BITS-1:0]    in_hi_val,
  input  logic [VALUE_BITS-1:0]    in_v,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FIELD_VALUE_W-1:0] out_snapped,
  output logic [FIELD_INDEX_W-1:0] out_note_index,
  output range_flag_t              out_flag,
  // result moved into the output register
  output logic                     done
);

  snap_ctl_t             pend;
  logic [IDXW-1:0]       lo;
  logic [IDXW-1:0]       hi;
  logic [VALUE_BITS-1:0] lo_val;
  logic [VALUE_BITS-1:0] hi_val;
  logic [VALUE_BITS-1:0] v;

  logic [VALUE_BITS-1:0]               d_lo;
  logic [VALUE_BITS-1:0]               d_hi;
  logic [VALUE_BITS-1:0]               pick_val;
  logic [IDXW-1:0]                     pick_idx;
  logic [VALUE_BITS+FIELD_VALUE_W-1:0] pick_val_ext;
  logic [IDXW+FIELD_INDEX_W-1:0]       pick_idx_ext;
  logic                                move;

  // pending token, held until the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (in_ctl.valid) begin
      pend.valid <= 1'b1;
    end else if (move) begin
      pend.valid <= 1'b0;
    end
    if (in_ctl.valid) begin
      pend.flag <= in_ctl.flag;
      lo        <= in_lo;
      hi        <= in_hi;
      lo_val    <= in_lo_val;
      hi_val    <= in_hi_val;
      v         <= in_v;
    end
  end

  // distances to both neighbors
  assign d_hi = (hi_val >= v) ? (hi_val - v) : (v - hi_val);
  assign d_lo = (v >= lo_val) ? (v - lo_val) : (lo_val - v);

  // select the entry
  always_comb begin
    pick_val = lo_val;
    pick_idx = lo;
    unique case (pend.flag)
      RANGE_EMPTY: begin
        pick_val = v;
        pick_idx = '0;
      end
      RANGE_BELOW: begin
        pick_val = lo_val;
        pick_idx = lo;
      end
      RANGE_ABOVE: begin
        pick_val = hi_val;
        pick_idx = hi;
      end
      RANGE_INSIDE: begin
        if (d_hi < d_lo) begin
          pick_val = hi_val;
          pick_idx = hi;
        end
      end
      default: begin
        pick_val = lo_val;
        pick_idx = lo;
      end
    endcase
  end

  assign pick_val_ext = (VALUE_BITS + FIELD_VALUE_W)'(pick_val);
  assign pick_idx_ext = (IDXW + FIELD_INDEX_W)'(pick_idx);

  // output register
  assign move = pend.valid && (!out_valid || out_ready);
  assign done = move;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (move) begin
      out_snapped    <= pick_val_ext[FIELD_VALUE_W-1:0];
      out_note_index <= pick_idx_ext[FIELD_INDEX_W-1:0];
      out_flag       <= pend.flag;
    end
  end

endmodule

@@ rtl/core/nearest_table_value_snap_core.sv @@
// ----------------------------------------------------------------------------
// nearest_table_value_snap_core: snap a frequency to the nearest table entry
// A word on the input stream either writes one entry of a sorted note table
// (tuser = 0) or queries it (tuser = 1). A query returns the nearest entry, its
// index and a range flag on the output stream; a write returns nothing. The user
// sets the entry count register via cfg_wr_en / cfg_wr_data while idle, unenforced.
//
// Usage:
//   - A write leaves the input ready; the next word may follow in the next cycle.
//   - A query walks a chain of bisection cells, each holding its own table
//     copy, STEPS = clog2(TABLE_DEPTH) of them. The head makes two end-point
//     reads, each cell narrows the window by one bisection step, and the tail
//     holds the token in its pending register and picks the neighbor into the
//     output register. No new word is taken until the result moves there.
//   - The result sits in an output register; the next word is accepted
//     while it waits. If the receiver stalls, a second result waits in the
//     tail and s_axis_tready stays low until it moves on.
//   - Reset clears the chain, the output register and the entry count. The
//     table is not cleared; with the count at zero, queries report it empty.
// ----------------------------------------------------------------------------
module nearest_table_value_snap_core
  import ntvs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data,    // entry_count
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [7:0] entry_index, [31:8] value
  input  logic [0:0]            s_axis_tuser,   // [0] func
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [23:0] snapped, [31:24] note_index
  output logic [1:0]            m_axis_tuser    // [1:0] range_flag
);

  localparam int unsigned IDXW  = $clog2(TABLE_DEPTH);
  localparam int unsigned STEPS = $clog2(TABLE_DEPTH);

  logic [COUNT_W-1:0] entry_count;
  logic               busy;

  logic                                accept;
  logic                                q_start;
  logic [VALUE_BITS+FIELD_VALUE_W-1:0] value_ext;
  logic [VALUE_BITS-1:0]               value;
  logic [IDXW+FIELD_INDEX_W-1:0]       slot_ext;
  logic                                wr_en;
  logic [IDXW-1:0]                     wr_addr;
  logic                                done;

  snap_ctl_t             ch_ctl    [STEPS+1];
  logic [IDXW-1:0]       ch_lo     [STEPS+1];
  logic [IDXW-1:0]       ch_hi     [STEPS+1];
  logic [VALUE_BITS-1:0] ch_lo_val [STEPS+1];
  logic [VALUE_BITS-1:0] ch_hi_val [STEPS+1];
  logic [VALUE_BITS-1:0] ch_v      [STEPS+1];

  logic [FIELD_VALUE_W-1:0] res_snapped;
  logic [FIELD_INDEX_W-1:0] res_index;
  range_flag_t              res_flag;

  // input word decode
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign q_start   = accept && (s_axis_tuser[0] == FUNC_QUERY);
  assign value_ext = (VALUE_BITS + FIELD_VALUE_W)'(s_axis_tdata[31:8]);
  assign value     = value_ext[VALUE_BITS-1:0];
  assign slot_ext  = (IDXW + FIELD_INDEX_W)'(s_axis_tdata[7:0]);
  assign wr_en     = accept && (s_axis_tuser[0] == FUNC_WRITE)
                     && (slot_ext < (IDXW + FIELD_INDEX_W)'(TABLE_DEPTH));
  assign wr_addr   = slot_ext[IDXW-1:0];

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  // one query in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  assign s_axis_tready = !busy;

  ntvs_head #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_head (
    .clk        (clk),
    .rst        (rst),
    .start      (q_start),
    .query      (value),
    .entry_count(entry_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (value),
    .out_ctl    (ch_ctl[0]),
    .out_lo     (ch_lo[0]),
    .out_hi     (ch_hi[0]),
    .out_lo_val (ch_lo_val[0]),
    .out_hi_val (ch_hi_val[0]),
    .out_v      (ch_v[0])
  );

  // bisection chain
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    ntvs_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (value),
      .in_ctl    (ch_ctl[k]),
      .in_lo     (ch_lo[k]),
      .in_hi     (ch_hi[k]),
      .in_lo_val (ch_lo_val[k]),
      .in_hi_val (ch_hi_val[k]),
      .in_v      (ch_v[k]),
      .out_ctl   (ch_ctl[k+1]),
      .out_lo    (ch_lo[k+1]),
      .out_hi    (ch_hi[k+1]),
      .out_lo_val(ch_lo_val[k+1]),
      .out_hi_val(ch_hi_val[k+1]),
      .out_v     (ch_v[k+1])
    );
  end

  ntvs_tail #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_tail (
    .clk           (clk),
    .rst           (rst),
    .in_ctl        (ch_ctl[STEPS]),
    .in_lo         (ch_lo[STEPS]),
    .in_hi         (ch_hi[STEPS]),
    .in_lo_val     (ch_lo_val[STEPS]),
    .in_hi_val     (ch_hi_val[STEPS]),
    .in_v          (ch_v[STEPS]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_snapped   (res_snapped),
    .out_note_index(res_index),
    .out_flag      (res_flag),
    .done          (done)
  );

  // output word packing
  assign m_axis_tdata = {res_index, res_snapped};
  assign m_axis_tuser = res_flag;

endmodule

@@ rtl/core/ntvs_checker.sv @@
// ----------------------------------------------------------------------------
// ntvs_checker: port-level checks for the nearest table value snap core
// Watches the stream ports only; bound to the top level.
// ----------------------------------------------------------------------------
module ntvs_checker
  import ntvs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [0:0]         s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [31:0]        m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  // no result word survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word valid after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // only one query in flight
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_QUERY)
      |=> !s_axis_tready)
    else $error("input accepted right after a query");

  // empty table and lower clamp always report the first index
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == RANGE_EMPTY || m_axis_tuser == RANGE_BELOW)
      |-> m_axis_tdata[31:24] == '0)
    else $error("nonzero index on empty or lower clamp result");

endmodule

bind nearest_table_value_snap_core ntvs_checker u_ntvs_checker (.*);
